FILE: hw/rtl/sxa_pkg.sv
// ----------------------------------------------------------------------------
// sxa_pkg: shared types and constants
// Constants of the seeding mixer and the command word passed from the
// controller to the datapath of the seeded xoshiro256+ advance block.
// ----------------------------------------------------------------------------
package sxa_pkg;

   localparam logic [63:0] GAMMA_C = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MUL_ONE = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MUL_TWO = 64'h94d049bb133111eb;

   localparam int unsigned SHIFT_A  = 30;
   localparam int unsigned SHIFT_B  = 27;
   localparam int unsigned SHIFT_C  = 31;
   localparam int unsigned STEP_SHL = 17;
   localparam int unsigned STEP_ROT = 45;

   // Multiply phases: low x low, then the two cross products.
   localparam logic [1:0] PHASE_LL = 2'd0;
   localparam logic [1:0] PHASE_HL = 2'd1;
   localparam logic [1:0] PHASE_LH = 2'd2;

   // Which state word a mix pass reads and which one it writes.
   localparam logic [1:0] MIX_S1 = 2'd0;
   localparam logic [1:0] MIX_S2 = 2'd1;
   localparam logic [1:0] MIX_S3 = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MIX_IN,
      ST_MUL1,
      ST_MIX_MID,
      ST_MUL2,
      ST_MIX_OUT,
      ST_STEP,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_MIX_IN,
      DP_MUL,
      DP_MIX_MID,
      DP_MIX_OUT,
      DP_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] mul_phase;
      logic       mul_k_two;
      logic [1:0] mix_idx;
   } dp_cmd_type;

endpackage

FILE: hw/rtl/sxa_datapath.sv
// ----------------------------------------------------------------------------
// sxa_datapath: state words, mixer and step logic
// Holds the four state words, the mixer operand and accumulator built on one
// shared 32x32 multiplier, and the iteration counter.
// ----------------------------------------------------------------------------
module sxa_datapath
   import sxa_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [63:0]           seed_value,
   input  logic [COUNT_BITS-1:0] iteration_count,
   output logic                  count_zero,
   output logic [63:0]           random_word
);

   logic [63:0] s0_ff, s0_in;
   logic [63:0] s1_ff, s1_in;
   logic [63:0] s2_ff, s2_in;
   logic [63:0] s3_ff, s3_in;
   logic [63:0] opnd_ff, opnd_in;
   logic [63:0] acc_ff, acc_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;

   logic [63:0] mul_k;
   logic [31:0] mul_x;
   logic [31:0] mul_y;
   logic [63:0] prod;
   logic [63:0] mix_src;
   logic [63:0] mix_res;
   logic [63:0] s3_x;

   assign mul_k = cmd.mul_k_two ? MUL_TWO : MUL_ONE;

   // The low 64 bits of a 64x64 product come from three 32x32 products.
   always_comb begin
      case (cmd.mul_phase)
         PHASE_LL: begin
            mul_x = opnd_ff[31:0];
            mul_y = mul_k[31:0];
         end
         PHASE_HL: begin
            mul_x = opnd_ff[63:32];
            mul_y = mul_k[31:0];
         end
         default: begin
            mul_x = opnd_ff[31:0];
            mul_y = mul_k[63:32];
         end
      endcase
   end

   assign prod = 64'(mul_x) * 64'(mul_y);

   always_comb begin
      case (cmd.mix_idx)
         MIX_S1:  mix_src = s0_ff;
         MIX_S2:  mix_src = s1_ff;
         default: mix_src = s2_ff;
      endcase
   end

   assign mix_res = acc_ff ^ (acc_ff >> SHIFT_C);
   assign s3_x    = s3_ff ^ s1_ff;

   always_comb begin
      s0_in   = s0_ff;
      s1_in   = s1_ff;
      s2_in   = s2_ff;
      s3_in   = s3_ff;
      opnd_in = opnd_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      unique case (cmd.op)
         DP_LOAD: begin
            s0_in  = seed_value + GAMMA_C;
            cnt_in = iteration_count;
         end
         DP_MIX_IN: begin
            opnd_in = mix_src ^ (mix_src >> SHIFT_A);
         end
         DP_MUL: begin
            if (cmd.mul_phase == PHASE_LL) begin
               acc_in = prod;
            end else begin
               acc_in = acc_ff + {prod[31:0], 32'd0};
            end
         end
         DP_MIX_MID: begin
            opnd_in = acc_ff ^ (acc_ff >> SHIFT_B);
         end
         DP_MIX_OUT: begin
            case (cmd.mix_idx)
               MIX_S1:  s1_in = mix_res + GAMMA_C;
               MIX_S2:  s2_in = mix_res + GAMMA_C;
               default: s3_in = mix_res;
            endcase
         end
         DP_STEP: begin
            s0_in  = s0_ff ^ s3_x;
            s1_in  = s1_ff ^ s2_ff ^ s0_ff;
            s2_in  = s2_ff ^ s0_ff ^ (s1_ff << STEP_SHL);
            s3_in  = {s3_x[63-STEP_ROT:0], s3_x[63:64-STEP_ROT]};
            cnt_in = cnt_ff - COUNT_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s0_ff   <= s0_in;
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
      s3_ff   <= s3_in;
      opnd_ff <= opnd_in;
      acc_ff  <= acc_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign count_zero  = (cnt_ff == '0);
   assign random_word = s0_ff + s3_ff;

`ifndef ASSERT_OFF
   a_step_needs_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_STEP) |-> !count_zero)
      else $error("step issued with the iteration counter at zero");

   a_step_counts_down: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_STEP) |=> (cnt_ff == $past(cnt_ff) - COUNT_BITS'(1)))
      else $error("iteration counter did not drop by one on a step");
`endif

endmodule

FILE: hw/rtl/sxa_ctrl.sv
// ----------------------------------------------------------------------------
// sxa_ctrl: sequencing controller
// Walks through seeding (three mix passes of two split multiplies each), the
// step loop and the result cycle, and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module sxa_ctrl
   import sxa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       count_zero,
   output logic       busy,
   output logic       rsp_valid,
   output dp_cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] mix_ff, mix_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      mix_in   = mix_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MIX_IN;
               mix_in   = MIX_S1;
            end
         end
         ST_MIX_IN: begin
            state_in = ST_MUL1;
            phase_in = PHASE_LL;
         end
         ST_MUL1: begin
            if (phase_ff == PHASE_LH) begin
               state_in = ST_MIX_MID;
               phase_in = PHASE_LL;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         ST_MIX_MID: begin
            state_in = ST_MUL2;
            phase_in = PHASE_LL;
         end
         ST_MUL2: begin
            if (phase_ff == PHASE_LH) begin
               state_in = ST_MIX_OUT;
               phase_in = PHASE_LL;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         ST_MIX_OUT: begin
            if (mix_ff == MIX_S3) begin
               state_in = ST_STEP;
               mix_in   = MIX_S1;
            end else begin
               state_in = ST_MIX_IN;
               mix_in   = mix_ff + 2'd1;
            end
         end
         ST_STEP: begin
            if (count_zero) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.op        = DP_NOP;
      cmd.mul_phase = phase_ff;
      cmd.mul_k_two = (state_ff == ST_MUL2);
      cmd.mix_idx   = mix_ff;
      busy          = (state_ff != ST_IDLE);
      rsp_valid     = (state_ff == ST_DONE);
      unique case (state_ff)
         ST_IDLE:    cmd.op = start ? DP_LOAD : DP_NOP;
         ST_MIX_IN:  cmd.op = DP_MIX_IN;
         ST_MUL1:    cmd.op = DP_MUL;
         ST_MIX_MID: cmd.op = DP_MIX_MID;
         ST_MUL2:    cmd.op = DP_MUL;
         ST_MIX_OUT: cmd.op = DP_MIX_OUT;
         ST_STEP:    cmd.op = count_zero ? DP_NOP : DP_STEP;
         default:    cmd.op = DP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PHASE_LL;
         mix_ff   <= MIX_S1;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         mix_ff   <= mix_in;
      end
   end

`ifndef ASSERT_OFF
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("multiply phase counter out of range");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted word did not start the sequence");
`endif

endmodule

FILE: hw/rtl/seeded_xoshiro256plus_advance.sv
// ----------------------------------------------------------------------------
// seeded_xoshiro256plus_advance: seeded xoshiro256+ advance
// Seeds four state words from a 64-bit seed, runs a number of xoshiro256+
// steps and returns the sum of words 0 and 3.
// ----------------------------------------------------------------------------
// Usage:
// An input word (req_seed_value, req_iteration_count) is taken at a clock
// edge where start is high and busy is low. busy then stays high until the
// result has been delivered, and start is ignored meanwhile.
// The result word appears on rsp_random_word for exactly one cycle with
// rsp_valid high; the receiver must take it in that cycle.
// After the accepting edge the block seeds the state (three mix passes,
// each of two 64-bit multiplies that run as three passes through one
// 32x32 multiplier), then runs one step per cycle until the counter is
// seen at zero, then gives the result cycle. The controller goes back to
// idle after the result cycle, and only then is the next word accepted.
// Synchronous reset returns the controller to idle; no item in flight
// survives it, and nothing is kept from one word to the next.
// ----------------------------------------------------------------------------
module seeded_xoshiro256plus_advance
   import sxa_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [63:0]           req_seed_value,
   input  logic [COUNT_BITS-1:0] req_iteration_count,
   output logic                  rsp_valid,
   output logic [63:0]           rsp_random_word
);

   dp_cmd_type cmd;
   logic       count_zero;

   sxa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .count_zero (count_zero),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   sxa_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .seed_value      (req_seed_value),
      .iteration_count (req_iteration_count),
      .count_zero      (count_zero),
      .random_word     (rsp_random_word)
   );

endmodule
